// File: hw/rtl/sva_pkg.sv
package sva_pkg;

	localparam int VOICE_COUNT   = 8;
	localparam int OSC_PER_VOICE = 4;
	localparam int OSC_POOL      = 16;

	localparam int SLOT_W = 3;
	localparam int NOTE_W = 7;
	localparam int OSC_W  = 3;
	localparam int VTOT_W = 4;
	localparam int OTOT_W = 5;
	localparam int STAT_W = 2;

	localparam logic OP_NOTE_ON = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [STAT_W-1:0] STAT_DONE       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_VOICE   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_OSC     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_VOICE_IDLE = 2'd3;

	typedef struct packed {
		logic              clr_en;
		logic [SLOT_W-1:0] clr_addr;
		logic              set_en;
		logic [SLOT_W-1:0] set_addr;
		logic [NOTE_W-1:0] set_note;
		logic [OSC_W-1:0]  set_osc;
	} sva_wr_t;

	typedef struct packed {
		logic              enabled;
		logic [NOTE_W-1:0] note;
		logic [OSC_W-1:0]  osc;
	} sva_rd_t;

endpackage

// File: hw/rtl/synth_voice_allocator_core.sv
// Sequence: a note-on scans the 8 slots, one slot per cycle, then commits and loads the
// result into the output register; a release skips the scan and goes straight to commit.
// Flow: one request at a time; in_stall is high until the result is loaded into the
// output register, so a new request is taken only after the last result is loaded.
// Reset: arst_n clears all slot enables, both totals, the sequencer and the output valid.
module synth_voice_allocator_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [sva_pkg::NOTE_W-1:0] note,
	input  logic [sva_pkg::OSC_W-1:0]  osc_request,
	input  logic [sva_pkg::SLOT_W-1:0] release_index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [sva_pkg::STAT_W-1:0] status,
	output logic [sva_pkg::SLOT_W-1:0] voice_slot,
	output logic                       replaced_valid,
	output logic [sva_pkg::SLOT_W-1:0] replaced_slot,
	output logic [sva_pkg::VTOT_W-1:0] active_voices,
	output logic [sva_pkg::OTOT_W-1:0] oscillators_in_use
);
	import sva_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;
	localparam logic [1:0] ST_OUT    = 2'd3;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VOICE_COUNT - 1);

	logic [1:0]        state_q;
	logic [SLOT_W-1:0] idx_q;
	logic              op_q;
	logic [NOTE_W-1:0] note_q;
	logic [OSC_W-1:0]  req_q;
	logic [SLOT_W-1:0] rel_q;
	logic              pick_found_q;
	logic [SLOT_W-1:0] pick_q;
	logic              dup_found_q;
	logic [SLOT_W-1:0] dup_q;
	logic [OSC_W-1:0]  dup_osc_q;
	logic [VTOT_W-1:0] vtot_q;
	logic [OTOT_W-1:0] otot_q;

	logic [STAT_W-1:0] res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_rvalid_q;
	logic [SLOT_W-1:0] res_rslot_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_rvalid_q;
	logic [SLOT_W-1:0] out_rslot_q;
	logic [VTOT_W-1:0] out_vtot_q;
	logic [OTOT_W-1:0] out_otot_q;

	logic [SLOT_W-1:0] rd_addr;
	sva_rd_t           rd;
	sva_wr_t           wr;

	logic              in_take;
	logic              out_free;
	logic [OSC_W-1:0]  req_clamped;
	logic [OTOT_W:0]   avail;
	logic              rel_in_range;

	logic [STAT_W-1:0] c_status;
	logic [SLOT_W-1:0] c_slot;
	logic              c_rvalid;
	logic [SLOT_W-1:0] c_rslot;
	logic [VTOT_W-1:0] c_vtot;
	logic [OTOT_W-1:0] c_otot;

	sva_voice_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(rd_addr),
		.rd     (rd),
		.wr     (wr)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign req_clamped = (osc_request > OSC_W'(OSC_PER_VOICE)) ? OSC_W'(OSC_PER_VOICE)
		: osc_request;

	assign rd_addr      = (op_q == OP_RELEASE) ? rel_q : idx_q;
	assign avail        = (OTOT_W+1)'(OSC_POOL) - {1'b0, otot_q};
	assign rel_in_range = ({1'b0, rel_q} < (SLOT_W+1)'(VOICE_COUNT));

	// commit decision: free the duplicate or released slot, claim the picked one
	always_comb begin
		wr       = '0;
		c_status = STAT_DONE;
		c_slot   = '0;
		c_rvalid = 1'b0;
		c_rslot  = '0;
		c_vtot   = vtot_q;
		c_otot   = otot_q;
		if (op_q == OP_NOTE_ON) begin
			if (!pick_found_q) begin
				c_status = STAT_NO_VOICE;
			end else if ((OTOT_W+1)'(req_q) > avail) begin
				c_status = STAT_NO_OSC;
			end else begin
				c_slot      = pick_q;
				wr.set_en   = (state_q == ST_COMMIT);
				wr.set_addr = pick_q;
				wr.set_note = note_q;
				wr.set_osc  = req_q;
				if (dup_found_q) begin
					c_rvalid    = 1'b1;
					c_rslot     = dup_q;
					wr.clr_en   = (state_q == ST_COMMIT);
					wr.clr_addr = dup_q;
					c_otot      = otot_q - OTOT_W'(dup_osc_q) + OTOT_W'(req_q);
				end else begin
					c_vtot = vtot_q + VTOT_W'(1);
					c_otot = otot_q + OTOT_W'(req_q);
				end
			end
		end else begin
			c_slot = rel_q;
			if (!rel_in_range || !rd.enabled) begin
				c_status = STAT_VOICE_IDLE;
			end else begin
				wr.clr_en   = (state_q == ST_COMMIT);
				wr.clr_addr = rel_q;
				c_vtot      = vtot_q - VTOT_W'(1);
				c_otot      = otot_q - OTOT_W'(rd.osc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			pick_found_q <= 1'b0;
			dup_found_q  <= 1'b0;
			vtot_q       <= '0;
			otot_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						idx_q        <= '0;
						pick_found_q <= 1'b0;
						dup_found_q  <= 1'b0;
						state_q      <= (op == OP_RELEASE) ? ST_COMMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// keep the lowest free slot and the lowest enabled slot on this note
					if (!rd.enabled && !pick_found_q) begin
						pick_found_q <= 1'b1;
					end
					if (rd.enabled && rd.note == note_q && !dup_found_q) begin
						dup_found_q <= 1'b1;
					end
					idx_q <= idx_q + SLOT_W'(1);
					if (idx_q == LAST_SLOT) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					vtot_q  <= c_vtot;
					otot_q  <= c_otot;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q   <= op;
			note_q <= note;
			req_q  <= req_clamped;
			rel_q  <= release_index;
		end
		if (state_q == ST_SCAN) begin
			if (!rd.enabled && !pick_found_q) begin
				pick_q <= idx_q;
			end
			if (rd.enabled && rd.note == note_q && !dup_found_q) begin
				dup_q     <= idx_q;
				dup_osc_q <= rd.osc;
			end
		end
		if (state_q == ST_COMMIT) begin
			res_status_q <= c_status;
			res_slot_q   <= c_slot;
			res_rvalid_q <= c_rvalid;
			res_rslot_q  <= c_rslot;
		end
		if (state_q == ST_OUT && out_free) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_rvalid_q <= res_rvalid_q;
			out_rslot_q  <= res_rslot_q;
			out_vtot_q   <= vtot_q;
			out_otot_q   <= otot_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = out_status_q;
	assign voice_slot         = out_slot_q;
	assign replaced_valid     = out_rvalid_q;
	assign replaced_slot      = out_rslot_q;
	assign active_voices      = out_vtot_q;
	assign oscillators_in_use = out_otot_q;

endmodule

// File: hw/rtl/sva_voice_table.sv
module sva_voice_table (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [sva_pkg::SLOT_W-1:0] rd_addr,
	output sva_pkg::sva_rd_t      rd,
	input  sva_pkg::sva_wr_t      wr
);
	import sva_pkg::*;

	logic [VOICE_COUNT-1:0] enabled_q;
	logic [VOICE_COUNT-1:0] enabled_d;
	logic [NOTE_W-1:0]      note_q [VOICE_COUNT];
	logic [OSC_W-1:0]       osc_q  [VOICE_COUNT];

	always_comb begin
		enabled_d = enabled_q;
		if (wr.clr_en) begin
			enabled_d[wr.clr_addr] = 1'b0;
		end
		if (wr.set_en) begin
			enabled_d[wr.set_addr] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= '0;
		end else begin
			enabled_q <= enabled_d;
		end
	end

	// note and count are only looked at while the slot is enabled
	always_ff @(posedge clk) begin
		if (wr.set_en) begin
			note_q[wr.set_addr] <= wr.set_note;
			osc_q[wr.set_addr]  <= wr.set_osc;
		end
	end

	assign rd.enabled = enabled_q[rd_addr];
	assign rd.note    = note_q[rd_addr];
	assign rd.osc     = osc_q[rd_addr];

endmodule
